// ===== hw/rtl/gram_matrix_row_update_unit_macros.svh =====
// Assertion helpers for the Gram matrix row update unit.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef GRAM_MATRIX_ROW_UPDATE_UNIT_MACROS_SVH
`define GRAM_MATRIX_ROW_UPDATE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMRU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gmru_pkg.sv =====
`default_nettype none

package gmru_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int ACTION_W = 3;
	localparam int ROW_W    = 6;
	localparam int MULT_W   = 32;
	localparam int EXP_W    = 6;
	localparam int VAL_W    = 64;
	localparam int CFG_W    = 7;
	localparam int STATUS_W = 2;
	localparam int SHAMT_W  = 7;

	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 72;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SWAP_ORDER = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_ADD   = 3'd2,
		ACT_SUB   = 3'd3,
		ACT_SCALE = 3'd4,
		ACT_SWAP  = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		AS_IJ,
		AS_JJ,
		AS_II,
		AS_JK,
		AS_IK
	} addr_sel_t;

	typedef enum logic [2:0] {
		WD_VAL,
		WD_ACC,
		WD_RDA,
		WD_RDB,
		WD_UPD
	} wd_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPT,
		OP_LDACC,
		OP_MUL1,
		OP_MUL2,
		OP_SHL,
		OP_COMB,
		OP_ACC
	} alu_op_t;

	typedef enum logic [1:0] {
		MS_GIJ,
		MS_GJJ,
		MS_T,
		MS_RDA
	} mop_sel_t;

	typedef enum logic [1:0] {
		SS_GIJ_1,
		SS_T_E1,
		SS_T_2E,
		SS_T_E
	} sh_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_D_RD2,
		ST_D_RD3,
		ST_A_SH,
		ST_A_CMB,
		ST_A_ACC,
		ST_M1A,
		ST_M2A,
		ST_SHA,
		ST_ACCA,
		ST_M1B,
		ST_M2B,
		ST_M1C,
		ST_M2C,
		ST_SHC,
		ST_ACCC,
		ST_D_WR,
		ST_L_RD,
		ST_L_M1,
		ST_L_M2,
		ST_L_SH,
		ST_L_WR,
		ST_S_RD,
		ST_S_W1,
		ST_S_W2,
		ST_S_DRD,
		ST_S_DW1,
		ST_S_DW2,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		addr_sel_t ra_sel;
		addr_sel_t rb_sel;
		logic      wr_en;
		addr_sel_t wa_sel;
		wd_sel_t   wd_sel;
		alu_op_t   op;
		mop_sel_t  msel;
		sh_sel_t   ssel;
		logic      k_clr;
		logic      k_inc;
		logic      res_ld;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic                idx_bad;
		logic                swap_bad;
		logic                same_ij;
		logic                k_done;
		logic                k_is_i;
		logic                k_is_j;
		logic                out_busy;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gram_matrix_row_update_unit.sv =====
// Gram matrix row update unit. The block holds the lower triangle of a symmetric
// Gram matrix of 64-bit two's complement entries in an internal memory of
// MAX_DIM*(MAX_DIM+1)/2 words, and applies one action per input beat: write an
// entry, read an entry, add or subtract row j to row i, add x*2^e times row j to
// row i, or swap rows i and j (j must not be below i). Every input beat yields
// exactly one output beat carrying the read value, a status code and an overflow
// flag that is set if any intermediate result wrapped. Entries are undefined
// until written; there is no clearing pass after reset, so software must write
// every entry it will later use. The active_rows register bounds the indices
// and the column walk; the user must write it over the cfg channel only while
// the unit is idle, as the block itself does not enforce this. One item is
// handled at a time. The time an action takes is set by the column walk, which
// does one read-modify-write of the memory per active column (skipping column i,
// and for the swap column j too), and in the scaled add by the 32-bit multipliers
// that form each 64 by 32 bit product in two steps. The next item is accepted
// once the result has moved into the output register, even if that result has
// not yet been taken downstream.
`default_nettype none

`include "gram_matrix_row_update_unit_macros.svh"

module gram_matrix_row_update_unit #(
	parameter int MAX_DIM = gmru_pkg::MAX_DIM_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration: active_rows.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gmru_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// s_tdata: row_i[5:0], row_j[11:6], multiplier[43:12], exponent[49:44],
	// entry_value[113:50], zero fill above.
	input  wire logic [gmru_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: action[2:0].
	input  wire logic [gmru_pkg::ACTION_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// m_tdata: read_value[63:0], status[65:64], overflow[66], zero fill above.
	output logic [gmru_pkg::OUT_DATA_W-1:0]        m_tdata
);

	logic [gmru_pkg::CFG_W-1:0]    active_rows_q;
	gmru_pkg::cmd_t                cmd;
	gmru_pkg::sts_t                sts;
	logic signed [gmru_pkg::VAL_W-1:0] read_value;
	logic [gmru_pkg::STATUS_W-1:0] status;
	logic                          overflow;

	// The register may be written at any time; the user keeps to idle periods.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_rows_q <= cfg_data;
		end
	end

	gmru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gmru_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.active_rows (active_rows_q),
		.action      (s_tuser),
		.row_i       (s_tdata[5:0]),
		.row_j       (s_tdata[11:6]),
		.multiplier  (s_tdata[43:12]),
		.exponent    (s_tdata[49:44]),
		.entry_value (s_tdata[113:50]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.read_value  (read_value),
		.status      (status),
		.overflow    (overflow)
	);

	// The result beat is packed with zero fill up to a whole number of bytes.
	assign m_tdata = {5'b0, overflow, status, read_value};

	// While a beat can be taken, the memory must be left alone.
	`GMRU_ASSERT_SAME(a_idle_no_mem, s_tready, !cmd.wr_en && !cmd.rd_en, "memory access while idle")
	// A result may only be loaded into a free or draining output register.
	`GMRU_ASSERT_SAME(a_res_free, cmd.res_ld, !sts.out_busy, "result overwrote a pending beat")
	// Once a beat is accepted the unit is busy in the next cycle.
	`GMRU_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready, "accepted two beats back to back")
	// The column walk never writes the diagonal entry of row i.
	`GMRU_ASSERT_SAME(a_no_diag_walk, cmd.wr_en && cmd.wa_sel == gmru_pkg::AS_IK, !sts.k_is_i, "walk wrote the diagonal")

endmodule

`default_nettype wire

// ===== hw/rtl/gmru_ctrl.sv =====
`default_nettype none

module gmru_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire gmru_pkg::sts_t sts,
	output gmru_pkg::cmd_t      cmd
);

	gmru_pkg::state_t state_q;
	gmru_pkg::state_t state_d;
	logic             act_known;
	logic             is_scale;

	assign act_known = (sts.act <= gmru_pkg::ACT_SWAP);
	assign is_scale  = (sts.act == gmru_pkg::ACT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gmru_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = gmru_pkg::ST_DECODE;
				end
			end
			gmru_pkg::ST_DECODE: begin
				state_d = gmru_pkg::ST_FINISH;
				if (act_known && !sts.idx_bad) begin
					case (sts.act)
						gmru_pkg::ACT_ADD, gmru_pkg::ACT_SUB, gmru_pkg::ACT_SCALE: begin
							state_d = gmru_pkg::ST_D_RD2;
						end
						gmru_pkg::ACT_SWAP: begin
							if (!sts.swap_bad && !sts.same_ij) begin
								state_d = gmru_pkg::ST_S_RD;
							end
						end
						default: state_d = gmru_pkg::ST_FINISH;
					endcase
				end
			end
			gmru_pkg::ST_D_RD2: state_d = gmru_pkg::ST_D_RD3;
			gmru_pkg::ST_D_RD3: state_d = is_scale ? gmru_pkg::ST_M1A : gmru_pkg::ST_A_SH;
			gmru_pkg::ST_A_SH:  state_d = gmru_pkg::ST_A_CMB;
			gmru_pkg::ST_A_CMB: state_d = gmru_pkg::ST_A_ACC;
			gmru_pkg::ST_A_ACC: state_d = gmru_pkg::ST_D_WR;
			gmru_pkg::ST_M1A:   state_d = gmru_pkg::ST_M2A;
			gmru_pkg::ST_M2A:   state_d = gmru_pkg::ST_SHA;
			gmru_pkg::ST_SHA:   state_d = gmru_pkg::ST_ACCA;
			gmru_pkg::ST_ACCA:  state_d = gmru_pkg::ST_M1B;
			gmru_pkg::ST_M1B:   state_d = gmru_pkg::ST_M2B;
			gmru_pkg::ST_M2B:   state_d = gmru_pkg::ST_M1C;
			gmru_pkg::ST_M1C:   state_d = gmru_pkg::ST_M2C;
			gmru_pkg::ST_M2C:   state_d = gmru_pkg::ST_SHC;
			gmru_pkg::ST_SHC:   state_d = gmru_pkg::ST_ACCC;
			gmru_pkg::ST_ACCC:  state_d = gmru_pkg::ST_D_WR;
			gmru_pkg::ST_D_WR:  state_d = gmru_pkg::ST_L_RD;
			gmru_pkg::ST_L_RD: begin
				if (sts.k_done) begin
					state_d = gmru_pkg::ST_FINISH;
				end else if (!sts.k_is_i) begin
					state_d = is_scale ? gmru_pkg::ST_L_M1 : gmru_pkg::ST_L_WR;
				end
			end
			gmru_pkg::ST_L_M1: state_d = gmru_pkg::ST_L_M2;
			gmru_pkg::ST_L_M2: state_d = gmru_pkg::ST_L_SH;
			gmru_pkg::ST_L_SH: state_d = gmru_pkg::ST_L_WR;
			gmru_pkg::ST_L_WR: state_d = gmru_pkg::ST_L_RD;
			gmru_pkg::ST_S_RD: begin
				if (sts.k_done) begin
					state_d = gmru_pkg::ST_S_DRD;
				end else if (!sts.k_is_i && !sts.k_is_j) begin
					state_d = gmru_pkg::ST_S_W1;
				end
			end
			gmru_pkg::ST_S_W1:  state_d = gmru_pkg::ST_S_W2;
			gmru_pkg::ST_S_W2:  state_d = gmru_pkg::ST_S_RD;
			gmru_pkg::ST_S_DRD: state_d = gmru_pkg::ST_S_DW1;
			gmru_pkg::ST_S_DW1: state_d = gmru_pkg::ST_S_DW2;
			gmru_pkg::ST_S_DW2: state_d = gmru_pkg::ST_FINISH;
			gmru_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					state_d = gmru_pkg::ST_IDLE;
				end
			end
			default: state_d = gmru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.ra_sel = gmru_pkg::AS_IJ;
		cmd.rb_sel = gmru_pkg::AS_JJ;
		cmd.wr_en  = 1'b0;
		cmd.wa_sel = gmru_pkg::AS_IJ;
		cmd.wd_sel = gmru_pkg::WD_VAL;
		cmd.op     = gmru_pkg::OP_NONE;
		cmd.msel   = gmru_pkg::MS_GIJ;
		cmd.ssel   = gmru_pkg::SS_GIJ_1;
		cmd.k_clr  = 1'b0;
		cmd.k_inc  = 1'b0;
		cmd.res_ld = 1'b0;
		case (state_q)
			gmru_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			gmru_pkg::ST_DECODE: begin
				if (act_known && !sts.idx_bad) begin
					case (sts.act)
						gmru_pkg::ACT_WRITE: begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = gmru_pkg::AS_IJ;
							cmd.wd_sel = gmru_pkg::WD_VAL;
						end
						gmru_pkg::ACT_READ: begin
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = gmru_pkg::AS_IJ;
						end
						gmru_pkg::ACT_SWAP: begin
							cmd.k_clr = 1'b1;
						end
						default: begin
							cmd.rd_en  = 1'b1;
							cmd.ra_sel = gmru_pkg::AS_IJ;
							cmd.rb_sel = gmru_pkg::AS_JJ;
						end
					endcase
				end
			end
			gmru_pkg::ST_D_RD2: begin
				cmd.op     = gmru_pkg::OP_CAPT;
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = gmru_pkg::AS_II;
			end
			gmru_pkg::ST_D_RD3: cmd.op = gmru_pkg::OP_LDACC;
			gmru_pkg::ST_A_SH: begin
				cmd.op   = gmru_pkg::OP_SHL;
				cmd.ssel = gmru_pkg::SS_GIJ_1;
			end
			gmru_pkg::ST_A_CMB: cmd.op = gmru_pkg::OP_COMB;
			gmru_pkg::ST_A_ACC, gmru_pkg::ST_ACCA, gmru_pkg::ST_ACCC: begin
				cmd.op = gmru_pkg::OP_ACC;
			end
			gmru_pkg::ST_M1A: begin
				cmd.op   = gmru_pkg::OP_MUL1;
				cmd.msel = gmru_pkg::MS_GIJ;
			end
			gmru_pkg::ST_M2A: begin
				cmd.op   = gmru_pkg::OP_MUL2;
				cmd.msel = gmru_pkg::MS_GIJ;
			end
			gmru_pkg::ST_SHA: begin
				cmd.op   = gmru_pkg::OP_SHL;
				cmd.ssel = gmru_pkg::SS_T_E1;
			end
			gmru_pkg::ST_M1B: begin
				cmd.op   = gmru_pkg::OP_MUL1;
				cmd.msel = gmru_pkg::MS_GJJ;
			end
			gmru_pkg::ST_M2B: begin
				cmd.op   = gmru_pkg::OP_MUL2;
				cmd.msel = gmru_pkg::MS_GJJ;
			end
			gmru_pkg::ST_M1C: begin
				cmd.op   = gmru_pkg::OP_MUL1;
				cmd.msel = gmru_pkg::MS_T;
			end
			gmru_pkg::ST_M2C: begin
				cmd.op   = gmru_pkg::OP_MUL2;
				cmd.msel = gmru_pkg::MS_T;
			end
			gmru_pkg::ST_SHC: begin
				cmd.op   = gmru_pkg::OP_SHL;
				cmd.ssel = gmru_pkg::SS_T_2E;
			end
			gmru_pkg::ST_D_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_II;
				cmd.wd_sel = gmru_pkg::WD_ACC;
				cmd.k_clr  = 1'b1;
			end
			gmru_pkg::ST_L_RD: begin
				if (!sts.k_done) begin
					if (sts.k_is_i) begin
						cmd.k_inc = 1'b1;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.ra_sel = gmru_pkg::AS_JK;
						cmd.rb_sel = gmru_pkg::AS_IK;
					end
				end
			end
			gmru_pkg::ST_L_M1: begin
				cmd.op   = gmru_pkg::OP_MUL1;
				cmd.msel = gmru_pkg::MS_RDA;
			end
			gmru_pkg::ST_L_M2: begin
				cmd.op   = gmru_pkg::OP_MUL2;
				cmd.msel = gmru_pkg::MS_RDA;
			end
			gmru_pkg::ST_L_SH: begin
				cmd.op   = gmru_pkg::OP_SHL;
				cmd.ssel = gmru_pkg::SS_T_E;
			end
			gmru_pkg::ST_L_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_IK;
				cmd.wd_sel = gmru_pkg::WD_UPD;
				cmd.k_inc  = 1'b1;
			end
			gmru_pkg::ST_S_RD: begin
				if (!sts.k_done) begin
					if (sts.k_is_i || sts.k_is_j) begin
						cmd.k_inc = 1'b1;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.ra_sel = gmru_pkg::AS_IK;
						cmd.rb_sel = gmru_pkg::AS_JK;
					end
				end
			end
			gmru_pkg::ST_S_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_IK;
				cmd.wd_sel = gmru_pkg::WD_RDB;
			end
			gmru_pkg::ST_S_W2: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_JK;
				cmd.wd_sel = gmru_pkg::WD_RDA;
				cmd.k_inc  = 1'b1;
			end
			gmru_pkg::ST_S_DRD: begin
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = gmru_pkg::AS_II;
				cmd.rb_sel = gmru_pkg::AS_JJ;
			end
			gmru_pkg::ST_S_DW1: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_II;
				cmd.wd_sel = gmru_pkg::WD_RDB;
			end
			gmru_pkg::ST_S_DW2: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = gmru_pkg::AS_JJ;
				cmd.wd_sel = gmru_pkg::WD_RDA;
			end
			gmru_pkg::ST_FINISH: cmd.res_ld = !sts.out_busy;
			default: cmd.op = gmru_pkg::OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gmru_datapath.sv =====
`default_nettype none

module gmru_datapath #(
	parameter int MAX_DIM = gmru_pkg::MAX_DIM_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gmru_pkg::cmd_t                  cmd,
	output gmru_pkg::sts_t                       sts,
	input  wire logic [gmru_pkg::CFG_W-1:0]      active_rows,
	input  wire logic [gmru_pkg::ACTION_W-1:0]   action,
	input  wire logic [gmru_pkg::ROW_W-1:0]      row_i,
	input  wire logic [gmru_pkg::ROW_W-1:0]      row_j,
	input  wire logic signed [gmru_pkg::MULT_W-1:0] multiplier,
	input  wire logic [gmru_pkg::EXP_W-1:0]      exponent,
	input  wire logic signed [gmru_pkg::VAL_W-1:0]  entry_value,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic signed [gmru_pkg::VAL_W-1:0]    read_value,
	output logic [gmru_pkg::STATUS_W-1:0]        status,
	output logic                                 overflow
);

	localparam int RW    = $clog2(MAX_DIM);
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = gmru_pkg::VAL_W;
	localparam int SW    = gmru_pkg::SHAMT_W;

	function automatic logic [AW-1:0] tri_addr(input logic [RW-1:0] a, input logic [RW-1:0] b);
		logic [RW-1:0]   r;
		logic [RW-1:0]   c;
		logic [RW:0]     r1;
		logic [2*RW:0]   p;
		r  = (a > b) ? a : b;
		c  = (a > b) ? b : a;
		r1 = {1'b0, r} + (RW+1)'(1);
		p  = {{(RW+1){1'b0}}, r} * {{RW{1'b0}}, r1};
		return AW'(p >> 1) + AW'(c);
	endfunction

	function automatic logic [AW-1:0] addr_of(input gmru_pkg::addr_sel_t sel,
			input logic [RW-1:0] ir, input logic [RW-1:0] jr, input logic [RW-1:0] kr);
		logic [AW-1:0] res;
		case (sel)
			gmru_pkg::AS_IJ: res = tri_addr(ir, jr);
			gmru_pkg::AS_JJ: res = tri_addr(jr, jr);
			gmru_pkg::AS_II: res = tri_addr(ir, ir);
			gmru_pkg::AS_JK: res = tri_addr(jr, kr);
			gmru_pkg::AS_IK: res = tri_addr(ir, kr);
			default:         res = tri_addr(ir, jr);
		endcase
		return res;
	endfunction

	// Shift left with a check that the value survives the trip back.
	function automatic logic [VW:0] shl_ov(input logic [VW-1:0] a, input logic [SW-1:0] s);
		logic [VW-1:0] r;
		logic          ov;
		if (a == '0 || s == '0) begin
			r  = a;
			ov = 1'b0;
		end else if (s >= SW'(VW)) begin
			r  = '0;
			ov = 1'b1;
		end else begin
			r  = a << s[5:0];
			ov = (($signed(r) >>> s[5:0]) != $signed(a));
		end
		return {ov, r};
	endfunction

	logic [gmru_pkg::ACTION_W-1:0] act_q;
	logic [gmru_pkg::ROW_W-1:0]    i_q;
	logic [gmru_pkg::ROW_W-1:0]    j_q;
	logic signed [gmru_pkg::MULT_W-1:0] x_q;
	logic [gmru_pkg::EXP_W-1:0]    e_q;
	logic [VW-1:0]                 val_q;
	logic [CW-1:0]                 k_q;
	logic [CW-1:0]                 n_rows;
	logic [RW-1:0]                 ir;
	logic [RW-1:0]                 jr;
	logic [RW-1:0]                 kr;

	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rda_q;
	logic [VW-1:0] rdb_q;
	logic [AW-1:0] ra;
	logic [AW-1:0] rb;
	logic [AW-1:0] wa;
	logic [VW-1:0] wd;

	logic [VW-1:0]        gij_q;
	logic [VW-1:0]        gjj_q;
	logic [VW-1:0]        acc_q;
	logic [VW-1:0]        t_q;
	logic signed [VW-1:0] ph_q;
	logic                 ov_q;

	logic [VW-1:0]        mop;
	logic signed [31:0]   m_hi;
	logic signed [32:0]   m_lo;
	logic signed [VW-1:0] mul_hi;
	logic signed [64:0]   lo_prod;
	logic signed [95:0]   full_prod;
	logic                 mul_ov;
	logic [VW-1:0]        sh_src;
	logic [SW-1:0]        sh_amt;
	logic [VW:0]          sh_res;
	logic [VW-1:0]        comb_res;
	logic                 comb_ov;
	logic [VW-1:0]        acc_sum;
	logic                 acc_ov;
	logic [VW-1:0]        upd_res;
	logic                 upd_ov;
	logic                 ov_set;
	logic                 is_add;
	logic                 is_sub;

	logic                        out_valid_q;
	logic [VW-1:0]               rd_out_q;
	logic [gmru_pkg::STATUS_W-1:0] st_out_q;
	logic                        ov_out_q;

	assign n_rows = (active_rows > MAX_DIM) ? CW'(MAX_DIM) : CW'(active_rows);
	assign ir     = RW'(i_q);
	assign jr     = RW'(j_q);
	assign kr     = k_q[RW-1:0];
	assign is_add = (act_q == gmru_pkg::ACT_ADD);
	assign is_sub = (act_q == gmru_pkg::ACT_SUB);

	assign sts.act      = act_q;
	assign sts.idx_bad  = ({2'b0, i_q} >= (gmru_pkg::ROW_W+2)'(n_rows))
		|| ({2'b0, j_q} >= (gmru_pkg::ROW_W+2)'(n_rows));
	assign sts.swap_bad = (j_q < i_q);
	assign sts.same_ij  = (j_q == i_q);
	assign sts.k_done   = (k_q == n_rows);
	assign sts.k_is_i   = ((gmru_pkg::ROW_W+CW)'(k_q) == (gmru_pkg::ROW_W+CW)'(i_q));
	assign sts.k_is_j   = ((gmru_pkg::ROW_W+CW)'(k_q) == (gmru_pkg::ROW_W+CW)'(j_q));
	assign sts.out_busy = out_valid_q && !out_ready;

	assign ra = addr_of(cmd.ra_sel, ir, jr, kr);
	assign rb = addr_of(cmd.rb_sel, ir, jr, kr);
	assign wa = addr_of(cmd.wa_sel, ir, jr, kr);

	// Multiply by x in two halves: signed upper word first, then unsigned lower word.
	always_comb begin
		case (cmd.msel)
			gmru_pkg::MS_GIJ: mop = gij_q;
			gmru_pkg::MS_GJJ: mop = gjj_q;
			gmru_pkg::MS_T:   mop = t_q;
			default:          mop = rda_q;
		endcase
		m_hi      = $signed(mop[63:32]);
		m_lo      = $signed({1'b0, mop[31:0]});
		mul_hi    = m_hi * x_q;
		lo_prod   = m_lo * x_q;
		full_prod = $signed({ph_q, 32'h0}) + 96'(lo_prod);
		mul_ov    = !((&full_prod[95:63]) || (~|full_prod[95:63]));
	end

	always_comb begin
		case (cmd.ssel)
			gmru_pkg::SS_GIJ_1: begin
				sh_src = gij_q;
				sh_amt = SW'(1);
			end
			gmru_pkg::SS_T_E1: begin
				sh_src = t_q;
				sh_amt = {1'b0, e_q} + SW'(1);
			end
			gmru_pkg::SS_T_2E: begin
				sh_src = t_q;
				sh_amt = {e_q, 1'b0};
			end
			default: begin
				sh_src = t_q;
				sh_amt = {1'b0, e_q};
			end
		endcase
		sh_res = shl_ov(sh_src, sh_amt);
	end

	always_comb begin
		if (is_sub) begin
			comb_res = gjj_q - t_q;
			comb_ov  = (gjj_q[63] != t_q[63]) && (comb_res[63] != gjj_q[63]);
		end else begin
			comb_res = t_q + gjj_q;
			comb_ov  = (gjj_q[63] == t_q[63]) && (comb_res[63] != t_q[63]);
		end
		acc_sum = acc_q + t_q;
		acc_ov  = (acc_q[63] == t_q[63]) && (acc_sum[63] != acc_q[63]);
		if (is_sub) begin
			upd_res = rdb_q - rda_q;
			upd_ov  = (rdb_q[63] != rda_q[63]) && (upd_res[63] != rdb_q[63]);
		end else if (is_add) begin
			upd_res = rdb_q + rda_q;
			upd_ov  = (rdb_q[63] == rda_q[63]) && (upd_res[63] != rdb_q[63]);
		end else begin
			upd_res = rdb_q + t_q;
			upd_ov  = (rdb_q[63] == t_q[63]) && (upd_res[63] != rdb_q[63]);
		end
	end

	always_comb begin
		case (cmd.wd_sel)
			gmru_pkg::WD_VAL: wd = val_q;
			gmru_pkg::WD_ACC: wd = acc_q;
			gmru_pkg::WD_RDA: wd = rda_q;
			gmru_pkg::WD_RDB: wd = rdb_q;
			default:          wd = upd_res;
		endcase
	end

	always_comb begin
		case (cmd.op)
			gmru_pkg::OP_MUL2: ov_set = mul_ov;
			gmru_pkg::OP_SHL:  ov_set = sh_res[VW];
			gmru_pkg::OP_COMB: ov_set = comb_ov;
			gmru_pkg::OP_ACC:  ov_set = acc_ov;
			default:           ov_set = 1'b0;
		endcase
		if (cmd.wr_en && cmd.wd_sel == gmru_pkg::WD_UPD && upd_ov) begin
			ov_set = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rda_q <= mem[ra];
			rdb_q <= mem[rb];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			i_q   <= row_i;
			j_q   <= row_j;
			x_q   <= multiplier;
			e_q   <= exponent;
			val_q <= entry_value;
		end
		case (cmd.op)
			gmru_pkg::OP_CAPT: begin
				gij_q <= rda_q;
				gjj_q <= rdb_q;
			end
			gmru_pkg::OP_LDACC: acc_q <= rda_q;
			gmru_pkg::OP_MUL1:  ph_q  <= mul_hi;
			gmru_pkg::OP_MUL2:  t_q   <= full_prod[63:0];
			gmru_pkg::OP_SHL:   t_q   <= sh_res[VW-1:0];
			gmru_pkg::OP_COMB:  t_q   <= comb_res;
			gmru_pkg::OP_ACC:   acc_q <= acc_sum;
			default: begin
			end
		endcase
		if (cmd.res_ld) begin
			rd_out_q <= (act_q == gmru_pkg::ACT_READ && !sts.idx_bad) ? rda_q : '0;
			ov_out_q <= ov_q;
			if (act_q > gmru_pkg::ACT_SWAP) begin
				st_out_q <= gmru_pkg::STATUS_OK;
			end else if (sts.idx_bad) begin
				st_out_q <= gmru_pkg::STATUS_RANGE;
			end else if (act_q == gmru_pkg::ACT_SWAP && sts.swap_bad) begin
				st_out_q <= gmru_pkg::STATUS_SWAP_ORDER;
			end else begin
				st_out_q <= gmru_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.load) begin
				ov_q <= 1'b0;
			end else if (ov_set) begin
				ov_q <= 1'b1;
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = rd_out_q;
	assign status     = st_out_q;
	assign overflow   = ov_out_q;

endmodule

`default_nettype wire
